### sv/qmm_pkg.sv
// Shared widths, register indexes and pipeline payload types for the motor mixer.
`default_nettype none

package qmm_pkg;

    // fixed-point format of throttle and corrections
    localparam int FRACTION_BITS = 8;
    localparam int IN_W          = 16;
    localparam int CFG_W         = 8;
    localparam int OUT_W         = 9;
    localparam int OUT_MAX       = (1 << OUT_W) - 1;

    // sum of three corrections
    localparam int CORR_W = IN_W + 2;
    // limit in fixed point, then signed headroom numerator
    localparam int LIM_W  = CFG_W + FRACTION_BITS;
    localparam int NUM_W  = ((LIM_W > IN_W) ? LIM_W : IN_W) + 1;
    // divisor magnitude: |correction| is at most 3 * 2^(IN_W-1)
    localparam int DEN_W  = CORR_W - 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int CMP_W  = (NUM_W > REM_W) ? NUM_W : REM_W;

    // scale is Q0.SCALE_BITS with one extra bit for exactly 1.0
    localparam int SCALE_BITS = 16;
    localparam int S_W        = SCALE_BITS + 1;
    localparam logic [S_W-1:0] SCALE_ONE = S_W'(1) << SCALE_BITS;

    // divider: quotient bits resolved per pipeline stage
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = SCALE_BITS / DIV_PER_STAGE;

    // output arithmetic
    localparam int PROD_W  = CORR_W + S_W + 1;
    localparam int ACC_W   = PROD_W + 1;
    localparam int RND_SH  = FRACTION_BITS + SCALE_BITS;

    // pipeline stage positions
    localparam int ST_DIV0  = 2;
    localparam int ST_SCALE = ST_DIV0 + DIV_STAGES + 1;
    localparam int ST_PROD  = ST_SCALE + 1;
    localparam int ST_OUT   = ST_PROD + 1;
    localparam int NST      = ST_OUT + 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 1'b1;

    localparam logic [CFG_W-1:0] FLOOR_RESET   = 8'd0;
    localparam logic [CFG_W-1:0] CEILING_RESET = 8'd255;

    // motor order: front-left, front-right, back-left, back-right
    typedef logic [3:0][CORR_W-1:0] t_corr4;

    // one side of the desaturation limit, mid-division
    typedef struct packed {
        logic                  lim;   // this side restricts the scale
        logic                  zero;  // no headroom: scale forced to 0
        logic [DEN_W-1:0]      den;
        logic [DEN_W-1:0]      rem;
        logic [SCALE_BITS-1:0] quo;
    } t_lim;

    typedef struct packed {
        logic [IN_W-1:0] base;
        t_corr4          corr;
        t_lim            lh;
        t_lim            ll;
    } t_div;

endpackage

`default_nettype wire

### sv/quad_motor_mixer_desaturate_unit.sv
// Quad X motor mixer with desaturation scaling: pipelined top level.
`default_nettype none

// Channel  | Direction | Handshake                  | Word
// ---------+-----------+----------------------------+-------------------------------------
// in       | in        | i_in_valid / o_in_ready    | base throttle, roll, pitch, yaw
// out      | out       | o_out_valid / i_out_ready  | four motor commands
// cfg      | in        | i_cfg_valid / o_cfg_ready  | register index, write data
//
// One word enters per cycle while the output is not stalled; the pipeline
// holds the 8-stage radix-4 scale dividers (two quotient bits per stage) plus
// mix, limit, divider set-up, scale select, multiply and round stages.
// Synchronous active-low reset clears the stage valids and returns the limit
// registers to floor 0 and ceiling 255.
// Each stage loads when it is empty or the stage after it moves on, so
// bubbles are squeezed out and a stalled output holds without loss.
// The cfg channel is always ready.

module quad_motor_mixer_desaturate_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [qmm_pkg::IN_W-1:0]            i_base_throttle,
    input  logic signed [qmm_pkg::IN_W-1:0]     i_roll_corr,
    input  logic signed [qmm_pkg::IN_W-1:0]     i_pitch_corr,
    input  logic signed [qmm_pkg::IN_W-1:0]     i_yaw_corr,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [qmm_pkg::OUT_W-1:0]           o_front_left,
    output logic [qmm_pkg::OUT_W-1:0]           o_front_right,
    output logic [qmm_pkg::OUT_W-1:0]           o_back_left,
    output logic [qmm_pkg::OUT_W-1:0]           o_back_right,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qmm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [qmm_pkg::CFG_W-1:0]           i_cfg_data
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // set up one limit side: headroom numerator over correction magnitude
    function automatic qmm_pkg::t_lim lim_init(
        input logic                                act,
        input logic signed [qmm_pkg::NUM_W-1:0]    num,
        input logic [qmm_pkg::DEN_W-1:0]           den
    );
        qmm_pkg::t_lim l;
        logic          nonpos;
        logic          cap;
        nonpos = num[qmm_pkg::NUM_W-1] || (num == '0);
        // headroom at least the correction: scale would reach 1.0
        cap    = !nonpos &&
                 (qmm_pkg::CMP_W'(unsigned'(num)) >= qmm_pkg::CMP_W'(den));
        l.lim  = act && !cap;
        l.zero = nonpos;
        l.den  = den;
        l.rem  = qmm_pkg::DEN_W'(num);
        l.quo  = '0;
        return l;
    endfunction

    // restoring division, DIV_PER_STAGE quotient bits
    function automatic qmm_pkg::t_lim div_step(input qmm_pkg::t_lim l_in);
        qmm_pkg::t_lim             l;
        logic [qmm_pkg::REM_W-1:0] wide;
        logic                      qbit;
        l = l_in;
        for (int k = 0; k < qmm_pkg::DIV_PER_STAGE; k++) begin
            wide = {l.rem, 1'b0};
            qbit = (wide >= {1'b0, l.den});
            if (qbit) begin
                wide = wide - {1'b0, l.den};
            end
            l.rem = qmm_pkg::DEN_W'(wide);
            l.quo = {l.quo[qmm_pkg::SCALE_BITS-2:0], qbit};
        end
        return l;
    endfunction

    // scale allowed by one side
    function automatic logic [qmm_pkg::S_W-1:0] lim_scale(input qmm_pkg::t_lim l);
        logic [qmm_pkg::S_W-1:0] s;
        if (!l.lim) begin
            s = qmm_pkg::SCALE_ONE;
        end else if (l.zero) begin
            s = '0;
        end else begin
            s = {1'b0, l.quo};
        end
        return s;
    endfunction

    // round half away from zero (value is non-negative once past the check),
    // saturate to the output field
    function automatic logic [qmm_pkg::OUT_W-1:0] round_out(
        input logic signed [qmm_pkg::ACC_W-1:0] v
    );
        logic [qmm_pkg::ACC_W-1:0] sh;
        logic [qmm_pkg::OUT_W-1:0] r;
        sh = (unsigned'(v) + (qmm_pkg::ACC_W'(1) << (qmm_pkg::RND_SH - 1)))
             >> qmm_pkg::RND_SH;
        if (v[qmm_pkg::ACC_W-1]) begin
            r = '0;
        end else if (sh > qmm_pkg::ACC_W'(qmm_pkg::OUT_MAX)) begin
            r = qmm_pkg::OUT_W'(qmm_pkg::OUT_MAX);
        end else begin
            r = qmm_pkg::OUT_W'(sh);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [qmm_pkg::CFG_W-1:0] r_floor;
    logic [qmm_pkg::CFG_W-1:0] r_ceiling;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= qmm_pkg::FLOOR_RESET;
            r_ceiling <= qmm_pkg::CEILING_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qmm_pkg::REG_FLOOR:   r_floor   <= i_cfg_data;
                qmm_pkg::REG_CEILING: r_ceiling <= i_cfg_data;
                default:              r_floor   <= r_floor;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and load enables
    // ------------------------------------------------------------------
    logic [qmm_pkg::NST-1:0] r_v;
    logic [qmm_pkg::NST-1:0] n_v;
    logic [qmm_pkg::NST-1:0] w_adv;

    // a stage loads when empty or when its word moves on
    assign w_adv[qmm_pkg::NST-1] = !r_v[qmm_pkg::NST-1] || i_out_ready;
    for (genvar g = 0; g < qmm_pkg::NST - 1; g++) begin : g_adv
        assign w_adv[g] = !r_v[g] || w_adv[g+1];
    end

    assign n_v = (w_adv & {r_v[qmm_pkg::NST-2:0], i_in_valid}) | (~w_adv & r_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_v[qmm_pkg::NST-1];

    // ------------------------------------------------------------------
    // Stage 1: X-layout mix
    // ------------------------------------------------------------------
    logic signed [qmm_pkg::CORR_W-1:0] w_roll;
    logic signed [qmm_pkg::CORR_W-1:0] w_pitch;
    logic signed [qmm_pkg::CORR_W-1:0] w_yaw;
    qmm_pkg::t_corr4                   n1_corr;
    logic [qmm_pkg::IN_W-1:0]          r1_base;
    qmm_pkg::t_corr4                   r1_corr;

    always_comb begin
        w_roll     = qmm_pkg::CORR_W'(i_roll_corr);
        w_pitch    = qmm_pkg::CORR_W'(i_pitch_corr);
        w_yaw      = qmm_pkg::CORR_W'(i_yaw_corr);
        n1_corr[0] = -w_roll + w_pitch + w_yaw;   // front-left
        n1_corr[1] =  w_roll + w_pitch - w_yaw;   // front-right
        n1_corr[2] = -w_roll - w_pitch - w_yaw;   // back-left
        n1_corr[3] =  w_roll - w_pitch + w_yaw;   // back-right
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_base <= i_base_throttle;
            r1_corr <= n1_corr;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: extremes of the corrections and headroom to each limit
    // ------------------------------------------------------------------
    logic signed [qmm_pkg::CORR_W-1:0] w_c0, w_c1, w_c2, w_c3;
    logic signed [qmm_pkg::CORR_W-1:0] w_hi01, w_hi23, w_lo01, w_lo23;
    logic signed [qmm_pkg::CORR_W-1:0] n2_hi, n2_lo;
    logic signed [qmm_pkg::NUM_W-1:0]  n2_numh, n2_numl;
    logic [qmm_pkg::LIM_W-1:0]         w_ceil_fx, w_floor_fx;

    logic [qmm_pkg::IN_W-1:0]          r2_base;
    qmm_pkg::t_corr4                   r2_corr;
    logic signed [qmm_pkg::CORR_W-1:0] r2_hi, r2_lo;
    logic signed [qmm_pkg::NUM_W-1:0]  r2_numh, r2_numl;

    always_comb begin
        w_c0   = $signed(r1_corr[0]);
        w_c1   = $signed(r1_corr[1]);
        w_c2   = $signed(r1_corr[2]);
        w_c3   = $signed(r1_corr[3]);
        w_hi01 = (w_c1 > w_c0) ? w_c1 : w_c0;
        w_hi23 = (w_c3 > w_c2) ? w_c3 : w_c2;
        w_lo01 = (w_c1 < w_c0) ? w_c1 : w_c0;
        w_lo23 = (w_c3 < w_c2) ? w_c3 : w_c2;
        n2_hi  = (w_hi23 > w_hi01) ? w_hi23 : w_hi01;
        n2_lo  = (w_lo23 < w_lo01) ? w_lo23 : w_lo01;

        w_ceil_fx  = {r_ceiling, {qmm_pkg::FRACTION_BITS{1'b0}}};
        w_floor_fx = {r_floor,   {qmm_pkg::FRACTION_BITS{1'b0}}};
        n2_numh = $signed(qmm_pkg::NUM_W'(w_ceil_fx)) - $signed(qmm_pkg::NUM_W'(r1_base));
        n2_numl = $signed(qmm_pkg::NUM_W'(r1_base)) - $signed(qmm_pkg::NUM_W'(w_floor_fx));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r2_base <= r1_base;
            r2_corr <= r1_corr;
            r2_hi   <= n2_hi;
            r2_lo   <= n2_lo;
            r2_numh <= n2_numh;
            r2_numl <= n2_numl;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divider set-up; stages 4 to 11: quotient bits
    // ------------------------------------------------------------------
    logic signed [qmm_pkg::CORR_W-1:0] w_neg_lo;
    qmm_pkg::t_div                     n3_div;
    qmm_pkg::t_div                     r_dv [qmm_pkg::DIV_STAGES+1];

    always_comb begin
        w_neg_lo       = -r2_lo;
        n3_div.base    = r2_base;
        n3_div.corr    = r2_corr;
        n3_div.lh      = lim_init(!r2_hi[qmm_pkg::CORR_W-1] && (r2_hi != '0), r2_numh,
                                  qmm_pkg::DEN_W'(r2_hi));
        n3_div.ll      = lim_init(r2_lo[qmm_pkg::CORR_W-1], r2_numl,
                                  qmm_pkg::DEN_W'(w_neg_lo));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[qmm_pkg::ST_DIV0]) begin
            r_dv[0] <= n3_div;
        end
    end

    for (genvar g = 1; g <= qmm_pkg::DIV_STAGES; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (w_adv[qmm_pkg::ST_DIV0+g]) begin
                r_dv[g].base <= r_dv[g-1].base;
                r_dv[g].corr <= r_dv[g-1].corr;
                r_dv[g].lh   <= div_step(r_dv[g-1].lh);
                r_dv[g].ll   <= div_step(r_dv[g-1].ll);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: common scale, the smaller of both sides (1.0 if neither limits)
    // ------------------------------------------------------------------
    logic [qmm_pkg::S_W-1:0]  w_sh, w_sl;
    logic [qmm_pkg::S_W-1:0]  r_s;
    logic [qmm_pkg::IN_W-1:0] r_s_base;
    qmm_pkg::t_corr4          r_s_corr;

    assign w_sh = lim_scale(r_dv[qmm_pkg::DIV_STAGES].lh);
    assign w_sl = lim_scale(r_dv[qmm_pkg::DIV_STAGES].ll);

    always_ff @(posedge i_clk) begin
        if (w_adv[qmm_pkg::ST_SCALE]) begin
            r_s      <= (w_sl < w_sh) ? w_sl : w_sh;
            r_s_base <= r_dv[qmm_pkg::DIV_STAGES].base;
            r_s_corr <= r_dv[qmm_pkg::DIV_STAGES].corr;
        end
    end

    // ------------------------------------------------------------------
    // Stage 13: correction times scale, one multiplier per motor
    // ------------------------------------------------------------------
    logic signed [qmm_pkg::PROD_W-1:0] r_prod [4];
    logic [qmm_pkg::IN_W-1:0]          r_p_base;

    for (genvar g = 0; g < 4; g++) begin : g_mul
        always_ff @(posedge i_clk) begin
            if (w_adv[qmm_pkg::ST_PROD]) begin
                r_prod[g] <= qmm_pkg::PROD_W'($signed(r_s_corr[g])) *
                             $signed(qmm_pkg::PROD_W'(r_s));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[qmm_pkg::ST_PROD]) begin
            r_p_base <= r_s_base;
        end
    end

    // ------------------------------------------------------------------
    // Stage 14: add base, round and saturate into the output register
    // ------------------------------------------------------------------
    logic signed [qmm_pkg::ACC_W-1:0] w_base_fx;
    logic signed [qmm_pkg::ACC_W-1:0] w_v [4];
    logic [qmm_pkg::OUT_W-1:0]        r_out [4];

    assign w_base_fx = $signed(qmm_pkg::ACC_W'(r_p_base) << qmm_pkg::SCALE_BITS);

    for (genvar g = 0; g < 4; g++) begin : g_out
        assign w_v[g] = w_base_fx + qmm_pkg::ACC_W'(r_prod[g]);
        always_ff @(posedge i_clk) begin
            if (w_adv[qmm_pkg::ST_OUT]) begin
                r_out[g] <= round_out(w_v[g]);
            end
        end
    end

    assign o_front_left  = r_out[0];
    assign o_front_right = r_out[1];
    assign o_back_left   = r_out[2];
    assign o_back_right  = r_out[3];

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the quad motor mixer: directed table, then randomised phases.
`default_nettype none

module tb_top;
    import qmm_pkg::*;

    localparam longint UNITY        = longint'(1) << SCALE_BITS;  // scale of exactly 1.0
    localparam int     N_PHASES     = 10;
    localparam int     WORDS_PER_PH = 120;
    localparam int     STALL_LIMIT  = 1000;  // cycles with no handshake at all
    localparam int     DRAIN_LIMIT  = 500;
    localparam int     SETTLE       = 20;    // pipeline is 14 deep

    typedef struct packed {
        logic [OUT_W-1:0] fl;
        logic [OUT_W-1:0] fr;
        logic [OUT_W-1:0] bl;
        logic [OUT_W-1:0] br;
    } t_motors;

    typedef enum logic [0:0] {ROW_WORD, ROW_LIMITS} t_row_kind;

    typedef struct {
        t_row_kind       kind;
        logic [CFG_W-1:0] lo_lim;
        logic [CFG_W-1:0] hi_lim;
        logic [IN_W-1:0] base;
        logic [IN_W-1:0] roll;
        logic [IN_W-1:0] pitch;
        logic [IN_W-1:0] yaw;
        logic            has_ref;
        t_motors         ref_cmds;
    } t_step;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [IN_W-1:0]        i_base_throttle = '0;
    logic signed [IN_W-1:0] i_roll_corr = '0;
    logic signed [IN_W-1:0] i_pitch_corr = '0;
    logic signed [IN_W-1:0] i_yaw_corr = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [OUT_W-1:0]       o_front_left;
    logic [OUT_W-1:0]       o_front_right;
    logic [OUT_W-1:0]       o_back_left;
    logic [OUT_W-1:0]       o_back_right;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = REG_FLOOR;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    // travels alongside the word: a hand-written expectation replaces the prediction
    logic    word_has_ref = 1'b0;
    t_motors word_ref = '0;

    // limits as the block should hold them, updated on accepted writes
    logic [CFG_W-1:0] floor_reg = FLOOR_RESET;
    logic [CFG_W-1:0] ceil_reg  = CEILING_RESET;

    t_motors     motor_cmds_due[$];
    t_step       steps[$];
    int          n_fail = 0;
    int          n_words = 0;
    int          n_settings = 0;
    int          quiet_cycles = 0;
    int unsigned stall_left = 0;
    bit          calm = 1'b0;

    quad_motor_mixer_desaturate_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_base_throttle (i_base_throttle),
        .i_roll_corr     (i_roll_corr),
        .i_pitch_corr    (i_pitch_corr),
        .i_yaw_corr      (i_yaw_corr),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_front_left    (o_front_left),
        .o_front_right   (o_front_right),
        .o_back_left     (o_back_left),
        .o_back_right    (o_back_right),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    // one side's limit on the scale, Q0.16; no headroom means no spread at all
    function automatic longint headroom_ratio(input longint num, input longint den);
        if (num <= 0 || den <= 0) return 0;
        return (num * UNITY) / den;
    endfunction

    // round half away from zero, then clip to the output field
    function automatic logic [OUT_W-1:0] round_cmd(input longint v);
        int     sh = FRACTION_BITS + SCALE_BITS;
        longint mag;
        if (v < 0) return '0;
        mag = (v + (longint'(1) <<< (sh - 1))) >>> sh;
        if (mag > OUT_MAX) mag = OUT_MAX;
        return mag[OUT_W-1:0];
    endfunction

    function automatic t_motors mix_motors(input logic [IN_W-1:0] base_in,
                                           input logic signed [IN_W-1:0] roll_in,
                                           input logic signed [IN_W-1:0] pitch_in,
                                           input logic signed [IN_W-1:0] yaw_in);
        longint           b, r, p, y, hi, lo, sc, q;
        longint           c [4];
        logic [OUT_W-1:0] cmd [4];
        b = longint'(base_in);
        r = longint'(roll_in);
        p = longint'(pitch_in);
        y = longint'(yaw_in);
        // X layout: FL, FR, BL, BR
        c[0] = -r + p + y;
        c[1] =  r + p - y;
        c[2] = -r - p - y;
        c[3] =  r - p + y;
        hi = c[0];
        lo = c[0];
        for (int i = 1; i < 4; i++) begin
            if (c[i] > hi) hi = c[i];
            if (c[i] < lo) lo = c[i];
        end
        sc = UNITY;
        if (hi > 0) begin
            q = headroom_ratio((longint'(ceil_reg) <<< FRACTION_BITS) - b, hi);
            if (q < sc) sc = q;
        end
        if (lo < 0) begin
            q = headroom_ratio(b - (longint'(floor_reg) <<< FRACTION_BITS), -lo);
            if (q < sc) sc = q;
        end
        if (sc < 0) sc = 0;
        for (int i = 0; i < 4; i++) cmd[i] = round_cmd(b * UNITY + c[i] * sc);
        return '{cmd[0], cmd[1], cmd[2], cmd[3]};
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // All sampling at the rising edge sees pre-edge values, as the block does.
    always @(posedge i_clk) begin
        t_motors want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FLOOR:   floor_reg = i_cfg_data;
                    REG_CEILING: ceil_reg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                n_words++;
                motor_cmds_due.push_back(word_has_ref ? word_ref :
                    mix_motors(i_base_throttle, i_roll_corr, i_pitch_corr, i_yaw_corr));
            end
            if (o_out_valid && i_out_ready) begin
                if (motor_cmds_due.size() == 0) begin
                    $error("motor word out with nothing outstanding");
                    n_fail++;
                end else begin
                    want = motor_cmds_due.pop_front();
                    check_field("front_left",  want.fl, o_front_left);
                    check_field("front_right", want.fr, o_front_right);
                    check_field("back_left",   want.bl, o_back_left);
                    check_field("back_right",  want.br, o_back_right);
                end
            end
        end
    end

    // watchdog: a hung handshake ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("no handshake for %0d cycles", STALL_LIMIT);
            $display("FAIL quad_motor_mixer_desaturate_unit");
            $finish;
        end
    end

    // receiver back-pressure: random stalls, none once calm
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 9);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- driving

    // Valid stays high into the next word unless a gap is taken, so it never
    // gets two updates in one step.
    task automatic send_word(input logic [IN_W-1:0] b, input logic [IN_W-1:0] r,
                             input logic [IN_W-1:0] p, input logic [IN_W-1:0] y,
                             input logic has_ref, input t_motors ref_cmds);
        i_in_valid      <= 1'b1;
        i_base_throttle <= b;
        i_roll_corr     <= r;
        i_pitch_corr    <= p;
        i_yaw_corr      <= y;
        word_has_ref    <= has_ref;
        word_ref        <= ref_cmds;
        do @(posedge i_clk); while (!o_in_ready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // drop valid and let every outstanding word come out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (motor_cmds_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] lo_lim, input logic [CFG_W-1:0] hi_lim);
        wait_idle();
        write_reg(REG_FLOOR, lo_lim);
        write_reg(REG_CEILING, hi_lim);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic t_motors all_at(input logic [OUT_W-1:0] v);
        return '{v, v, v, v};
    endfunction

    function automatic t_step word_row(input logic [IN_W-1:0] b, input logic [IN_W-1:0] r,
                                       input logic [IN_W-1:0] p, input logic [IN_W-1:0] y);
        t_step s;
        s = '{ROW_WORD, '0, '0, b, r, p, y, 1'b0, '0};
        return s;
    endfunction

    function automatic t_step ref_row(input logic [IN_W-1:0] b, input logic [IN_W-1:0] r,
                                      input logic [IN_W-1:0] p, input logic [IN_W-1:0] y,
                                      input logic [OUT_W-1:0] v);
        t_step s;
        s = '{ROW_WORD, '0, '0, b, r, p, y, 1'b1, all_at(v)};
        return s;
    endfunction

    function automatic t_step limits_row(input logic [CFG_W-1:0] lo_lim,
                                         input logic [CFG_W-1:0] hi_lim);
        t_step s;
        s = '{ROW_LIMITS, lo_lim, hi_lim, '0, '0, '0, '0, 1'b0, '0};
        return s;
    endfunction

    // throttle mostly inside the limits, often on them or just across
    function automatic logic [IN_W-1:0] pick_base(input logic [CFG_W-1:0] lo_lim,
                                                  input logic [CFG_W-1:0] hi_lim);
        int lo_fx, hi_fx;
        lo_fx = int'(lo_lim) << FRACTION_BITS;
        hi_fx = int'(hi_lim) << FRACTION_BITS;
        case ($urandom_range(0, 9))
            0, 1: return IN_W'($urandom);
            2:    return IN_W'(lo_fx);
            3:    return IN_W'(hi_fx);
            4:    return IN_W'(lo_fx + int'($urandom_range(0, 600)) - 300);
            5:    return IN_W'(hi_fx + int'($urandom_range(0, 600)) - 300);
            default: begin
                if (lo_fx <= hi_fx) return IN_W'($urandom_range(lo_fx, hi_fx));
                return IN_W'($urandom);
            end
        endcase
    endfunction

    // small, medium and full-scale corrections, so the scale lands all over [0,1]
    function automatic logic [IN_W-1:0] pick_corr();
        case ($urandom_range(0, 7))
            0:       return '0;
            1, 2:    return IN_W'($urandom_range(0, 511) - 256);
            3, 4:    return IN_W'($urandom_range(0, 8191) - 4096);
            default: return IN_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [CFG_W-1:0] lo_lim, hi_lim;

        // reset limits: floor 0, ceiling 255
        steps.push_back(ref_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'd0));
        steps.push_back(ref_row(16'h0080, 16'h0000, 16'h0000, 16'h0000, 9'd1));   // half rounds up
        steps.push_back(ref_row(16'h007F, 16'h0000, 16'h0000, 16'h0000, 9'd0));
        steps.push_back(ref_row(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 9'd256)); // no spread
        steps.push_back(ref_row(16'hFFFF, 16'h0100, 16'h0000, 16'h0000, 9'd256)); // over ceiling
        steps.push_back(ref_row(16'h0000, 16'h0000, 16'h0100, 16'h0000, 9'd0));   // on floor
        steps.push_back(word_row(16'h8000, 16'h0100, 16'h0000, 16'h0000));
        steps.push_back(word_row(16'h8000, 16'hFF00, 16'h0000, 16'h0000));
        steps.push_back(word_row(16'h8000, 16'h0000, 16'h0100, 16'h0000));
        steps.push_back(word_row(16'h8000, 16'h0000, 16'hFF00, 16'h0000));
        steps.push_back(word_row(16'h8000, 16'h0000, 16'h0000, 16'h0100));
        steps.push_back(word_row(16'h8000, 16'h0000, 16'h0000, 16'hFF00));
        steps.push_back(word_row(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        steps.push_back(word_row(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        steps.push_back(word_row(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF)); // wide spread
        steps.push_back(word_row(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000));
        // floor above ceiling: any spread collapses onto the base
        steps.push_back(limits_row(8'd200, 8'd50));
        steps.push_back(ref_row(16'h6400, 16'h0100, 16'h0000, 16'h0000, 9'd100));
        steps.push_back(ref_row(16'h6400, 16'h0000, 16'h0000, 16'h0000, 9'd100));
        steps.push_back(limits_row(8'd255, 8'd255));
        steps.push_back(ref_row(16'hFF00, 16'h0005, 16'h0000, 16'h0000, 9'd255));
        steps.push_back(limits_row(8'd0, 8'd0));
        steps.push_back(ref_row(16'h0080, 16'h0001, 16'h0000, 16'h0000, 9'd1));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[k]) begin
            if (steps[k].kind == ROW_LIMITS)
                set_limits(steps[k].lo_lim, steps[k].hi_lim);
            else
                send_word(steps[k].base, steps[k].roll, steps[k].pitch, steps[k].yaw,
                          steps[k].has_ref, steps[k].ref_cmds);
        end

        // randomised phases, each under its own pair of limits
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin lo_lim = 8'd0;   hi_lim = 8'd255; end
                1: begin lo_lim = 8'd0;   hi_lim = 8'd0;   end
                2: begin lo_lim = 8'd255; hi_lim = 8'd255; end
                3: begin lo_lim = 8'd200; hi_lim = 8'd50;  end
                4: begin lo_lim = 8'd64;  hi_lim = 8'd192; end
                5: begin lo_lim = CFG_W'($urandom); hi_lim = CFG_W'($urandom); end
                default: begin
                    lo_lim = CFG_W'($urandom_range(0, 255));
                    hi_lim = CFG_W'($urandom_range(lo_lim, 255));
                end
            endcase
            set_limits(lo_lim, hi_lim);
            calm = (ph == N_PHASES - 1);
            repeat (WORDS_PER_PH)
                send_word(pick_base(lo_lim, hi_lim), pick_corr(), pick_corr(), pick_corr(),
                          1'b0, '0);
        end

        i_in_valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && motor_cmds_due.size() != 0; w++)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (motor_cmds_due.size() != 0) begin
            $error("%0d motor words never came out", motor_cmds_due.size());
            n_fail++;
        end

        $display("Mixed %0d throttle/attitude words under %0d floor/ceiling settings,",
                 n_words, n_settings);
        $display("with random gaps and back-pressure and a final stall-free phase.");
        if (n_fail == 0)
            $display("PASS quad_motor_mixer_desaturate_unit");
        else
            $display("FAIL quad_motor_mixer_desaturate_unit");
        $finish;
    end

endmodule

`default_nettype wire

### quad_motor_mixer_desaturate_unit.f
sv/qmm_pkg.sv
sv/quad_motor_mixer_desaturate_unit.sv
verif/tb_top.sv
